// ----- rtl/csr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csr_pkg;

  localparam int T_BITS      = 16;
  localparam int STEP_BITS   = 24;
  localparam int PHASE_BITS  = STEP_BITS + 1;
  localparam int OUT_BITS    = 16;
  localparam int OUT_MAX     = 32767;
  localparam int OUT_MIN     = -32768;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS);

  localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd65536;
  localparam logic [2:0]           FILL_FULL  = 3'd4;

  typedef struct packed {
    logic shift;
    logic issue;
    logic last;
    logic wrap;
  } csr_cmd_t;

  typedef struct packed {
    logic pos_done;
    logic next_done;
    logic adv;
  } csr_stat_t;

endpackage

`default_nettype wire

// ----- rtl/csr_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface csr_in_if #(
  parameter int SampleBits = 18
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/csr_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface csr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [csr_pkg::OUT_BITS-1:0]  out_sample;
  logic                                 last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink (input valid, input out_sample, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/csr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire csr_pkg::csr_stat_t stat_i,
  output csr_pkg::csr_cmd_t       cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;
  localparam logic [csr_pkg::CNT_BITS-1:0] CntLast =
    csr_pkg::CNT_BITS'(csr_pkg::MAX_RESULTS - 1);

  logic                         state_q, state_d;
  logic [2:0]                   fill_q, fill_d, fill_nx;
  logic [csr_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);
  assign fill_nx    = (fill_q == csr_pkg::FILL_FULL) ? fill_q : fill_q + 3'd1;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.shift = 1'b1;
          fill_d      = fill_nx;
          if (fill_nx == csr_pkg::FILL_FULL) begin
            state_d = StRun;
            cnt_d   = '0;
          end
        end
      end
      StRun: begin
        if (stat_i.pos_done) begin
          cmd_o.wrap = 1'b1;
          state_d    = StIdle;
        end else if (stat_i.adv) begin
          cmd_o.issue = 1'b1;
          cnt_d       = cnt_q + csr_pkg::CNT_BITS'(1);
          if (stat_i.next_done || (cnt_q == CntLast)) begin
            cmd_o.last = 1'b1;
            cmd_o.wrap = 1'b1;
            state_d    = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csr_datapath #(
  parameter int PHASE_FRAC_BITS = 16,
  parameter int SAMPLE_BITS     = 18
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [csr_pkg::STEP_BITS-1:0]         cfg_data_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  wire csr_pkg::csr_cmd_t                     cmd_i,
  output csr_pkg::csr_stat_t                         stat_o,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic signed [csr_pkg::OUT_BITS-1:0]        out_sample_o,
  output logic                                       out_last_o
);

  localparam int CoefBits = SAMPLE_BITS + 6;
  localparam int HBits    = SAMPLE_BITS + 22;
  localparam int QBits    = HBits - 17;
  localparam int RBits    = HBits - 16;
  localparam int PhW      = csr_pkg::PHASE_BITS;
  localparam int SW       = csr_pkg::STEP_BITS;
  localparam int TW       = csr_pkg::T_BITS;
  localparam int OW       = csr_pkg::OUT_BITS;

  localparam logic [PhW-1:0] One     = PhW'(1) << PHASE_FRAC_BITS;
  localparam logic [SW-1:0]  MinStep = SW'(One >> 6);
  localparam logic signed [RBits-1:0] SatHi = RBits'(csr_pkg::OUT_MAX);
  localparam logic signed [RBits-1:0] SatLo = RBits'(csr_pkg::OUT_MIN);

  // step and read position
  logic [SW-1:0]  step_q, step_eff;
  logic [PhW-1:0] phase_q, phase_d, sum, wrap_src, wrap_sub;
  logic [TW-1:0]  t_cur;
  logic           adv;

  assign step_eff = (step_q < MinStep) ? MinStep : step_q;
  assign sum      = phase_q + PhW'(step_eff);
  assign wrap_src = cmd_i.issue ? sum : phase_q;
  assign wrap_sub = wrap_src - One;
  assign adv      = !out_valid_o || out_ready_i;

  assign stat_o.pos_done  = (phase_q >= One);
  assign stat_o.next_done = (sum >= One);
  assign stat_o.adv       = adv;

  always_comb begin
    phase_d = phase_q;
    if (cmd_i.wrap) begin
      phase_d = {1'b0, wrap_sub[SW-1:0]};
    end else if (cmd_i.issue) begin
      phase_d = sum;
    end
  end

  if (PHASE_FRAC_BITS >= TW) begin : g_t_trunc
    assign t_cur = phase_q[PHASE_FRAC_BITS-1 -: TW];
  end else begin : g_t_pad
    assign t_cur = {phase_q[PHASE_FRAC_BITS-1:0], {(TW-PHASE_FRAC_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= csr_pkg::STEP_RESET;
      phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      phase_q <= phase_d;
    end
  end

  // sample window and Catmull-Rom coefficients (doubled units)
  logic signed [SAMPLE_BITS-1:0] win_q [4];
  logic signed [CoefBits-1:0]    e0, e1, e2, e3, a_c, b_c, c_c, d_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= sample_i;
    end
  end

  assign e0  = CoefBits'(win_q[0]);
  assign e1  = CoefBits'(win_q[1]);
  assign e2  = CoefBits'(win_q[2]);
  assign e3  = CoefBits'(win_q[3]);
  assign c_c = e2 - e0;
  assign a_c = c_c + (e3 - e1) + ((e1 - e2) <<< 2);
  assign b_c = ((e2 - e1) <<< 1) - c_c - a_c;
  assign d_c = e1 <<< 1;

  // Horner pipeline
  logic [3:0]                 vld_q, last_q;
  logic signed [CoefBits-1:0] a0_q, b0_q, c0_q, d0_q, c1_q, d1_q, d2_q;
  logic [TW-1:0]              t0_q, t1_q, t2_q;
  logic signed [HBits-1:0]    h1_q, h2_q, h3_q, h1_d, h2_d, h3_d;
  logic signed [CoefBits+TW:0] p1;
  logic signed [HBits+TW:0]   p2, p3;

  assign p1   = a0_q * $signed({1'b0, t0_q});
  assign h1_d = HBits'(p1) + (HBits'(b0_q) <<< 16);
  assign p2   = h1_q * $signed({1'b0, t1_q});
  assign h2_d = HBits'(p2 >>> 16) + (HBits'(c1_q) <<< 16);
  assign p3   = h2_q * $signed({1'b0, t2_q});
  assign h3_d = HBits'(p3 >>> 16) + (HBits'(d2_q) <<< 16);

  // round half to even, saturate
  logic signed [QBits-1:0] q;
  logic signed [RBits-1:0] qr;
  logic                    rnd_up;
  logic signed [OW-1:0]    sat;

  assign q      = $signed(h3_q[HBits-1:17]);
  assign rnd_up = h3_q[16] && ((h3_q[15:0] != '0) || q[0]);
  assign qr     = RBits'(q) + $signed({{(RBits-1){1'b0}}, rnd_up});

  always_comb begin
    if (qr > SatHi) begin
      sat = OW'(csr_pkg::OUT_MAX);
    end else if (qr < SatLo) begin
      sat = OW'(csr_pkg::OUT_MIN);
    end else begin
      sat = qr[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[2:0], cmd_i.issue};
      out_valid_o <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q       <= {last_q[2:0], cmd_i.last};
      a0_q         <= a_c;
      b0_q         <= b_c;
      c0_q         <= c_c;
      d0_q         <= d_c;
      t0_q         <= t_cur;
      h1_q         <= h1_d;
      c1_q         <= c0_q;
      d1_q         <= d0_q;
      t1_q         <= t0_q;
      h2_q         <= h2_d;
      d2_q         <= d1_q;
      t2_q         <= t1_q;
      h3_q         <= h3_d;
      out_sample_o <= sat;
      out_last_o   <= last_q[3];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cubic_spline_resampler.sv -----
// Pipeline: each result passes coefficient, Horner h1..h3 and output registers.
// Input: once four words are held, a word holds the sequencer until all of its
//   results (0..64) are issued; no new word is accepted meanwhile.
//   Results leave at one per cycle while the output is not stalled.
// Reset: rst_ni asynchronous, active low; step returns to 65536, read position and
//   fill count to zero, pipeline emptied. No memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cubic_spline_resampler #(
  parameter int PHASE_FRAC_BITS = 16,
  parameter int SAMPLE_BITS     = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [csr_pkg::STEP_BITS-1:0] cfg_data_i,
  csr_in_if.sink                             in_i,
  csr_out_if.source                          out_o
);

  csr_pkg::csr_cmd_t  cmd;
  csr_pkg::csr_stat_t stat;
  logic               in_ready;
  logic               out_valid;
  logic               out_last;
  logic signed [csr_pkg::OUT_BITS-1:0] out_sample;

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.out_sample  = out_sample;
  assign out_o.last_of_run = out_last;

  csr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csr_datapath #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (SAMPLE_BITS'($unsigned(in_i.in_sample))),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .out_sample_o (out_sample),
    .out_last_o   (out_last)
  );

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !stat.pos_done && stat.adv)
    else $error("sample issued past end of interval");

  a_no_issue_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> !cmd.issue && !cmd.wrap)
    else $error("window shift overlaps evaluation");

  a_last_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.last |-> cmd.issue && cmd.wrap)
    else $error("last word without position wrap");

endmodule

`default_nettype wire
